>>> design/kdb_pkg.sv
// Shared constants and types for the key debounce and press detector.
`default_nettype none
package kdb_pkg;

  localparam int KDB_NUM_KEYS = 4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS_TICKS = 2'd1;
  localparam logic [1:0] CFG_TOGGLE_DELAY_MS  = 2'd2;

  // Register values after reset.
  localparam logic [7:0]  RST_DEBOUNCE_TICKS   = 8'd2;
  localparam logic [7:0]  RST_LONG_PRESS_TICKS = 8'd25;
  localparam logic [15:0] RST_TOGGLE_DELAY_MS  = 16'd1000;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [7:0]  long_press_ticks;
    logic [15:0] toggle_delay_ms;
  } kdb_cfg_t;

  // Release events of one key for the current scan.
  typedef struct packed {
    logic tap;
    logic hold;
  } kdb_key_ev_t;

endpackage
`default_nettype wire

>>> design/kdb_key_fsm.sv
// Per-key debounce and short/long press state machine.
`default_nettype none
module kdb_key_fsm
  import kdb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        pressed,
  input  wire kdb_cfg_t    cfg,
  output kdb_key_ev_t      ev
);

  typedef enum logic [1:0] {
    PH_RELEASED,
    PH_DEBOUNCE,
    PH_PRESSED,
    PH_LONG
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] count_inc;

  assign count_inc = count_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    ev        = '0;
    unique case (phase_r)
      PH_RELEASED: begin
        if (pressed) begin
          phase_nxt = PH_DEBOUNCE;
          count_nxt = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (pressed) begin
          count_nxt = count_inc;
          if (count_inc >= cfg.debounce_ticks) begin
            phase_nxt = PH_PRESSED;
            count_nxt = '0;
          end
        end else begin
          phase_nxt = PH_RELEASED;
          count_nxt = '0;
        end
      end
      PH_PRESSED: begin
        if (!pressed) begin
          ev.tap    = 1'b1;
          phase_nxt = PH_RELEASED;
        end else begin
          count_nxt = count_inc;
          if (count_inc >= cfg.long_press_ticks) begin
            phase_nxt = PH_LONG;
          end
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          ev.hold   = 1'b1;
          phase_nxt = PH_RELEASED;
          count_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_RELEASED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASED;
      count_r <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/kdb_run_toggle.sv
// Delayed run flag toggle armed by a key 0 short press.
`default_nettype none
module kdb_run_toggle
  import kdb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        arm,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] toggle_delay_ms,
  output logic             run_nxt,
  output logic             waiting_nxt
);

  logic        run_r;
  logic        waiting_r;
  logic [31:0] due_r, due_nxt;
  logic [31:0] remain;
  logic        armed;
  logic        fire;

  assign due_nxt = arm ? (now_ms + {16'd0, toggle_delay_ms}) : due_r;
  assign armed   = arm | waiting_r;
  // Wrapping compare: the toggle is due once the remaining time is zero or negative.
  assign remain  = due_nxt - now_ms;
  assign fire    = armed && ((remain == 32'd0) || remain[31]);

  assign run_nxt     = run_r ^ fire;
  assign waiting_nxt = armed & ~fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      waiting_r <= 1'b0;
      due_r     <= '0;
    end else if (en) begin
      run_r     <= run_nxt;
      waiting_r <= waiting_nxt;
      due_r     <= due_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/key_debounce_short_long_press.sv
// Top level: four-key debounce with short/long press decoding and a delayed run toggle.
//
// Each input word is one scan tick: four active-low key levels and the current
// millisecond time. Every accepted word gives exactly one result word with the
// short-press mask, the menu requests (down, up, enter, back), the run flag and
// whether a delayed toggle is still pending.
// The block is a two-register pipeline: an input register, then the key machines
// and toggle timer as short logic, then the result register. A word passes from
// the input register into the result register once that register is free; one
// word is taken every cycle for as long as the output side keeps taking results.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; after that in_tready falls.
// Configuration writes (index 0 debounce ticks, 1 long press ticks, 2 toggle
// delay in ms) are always ready and take effect on the next scan; indexes
// beyond the list are ignored. Write them only while the block is idle.
// Synchronous reset empties both pipeline registers, sets all keys released,
// clears the run flag and pending toggle, and restores the register defaults.
`default_nettype none
module key_debounce_short_long_press
  import kdb_pkg::*;
#(
  parameter int NUM_KEYS = KDB_NUM_KEYS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input words.
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [NUM_KEYS-1:0] key_levels, [NUM_KEYS+31:NUM_KEYS] now_ms, zero padding above
  input  wire logic [((NUM_KEYS+32+7)/8)*8-1:0] in_tdata,
  // Result words.
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [NUM_KEYS-1:0] short_press_mask, then down_request, up_request,
  // enter_request, back_request, run_flag, toggle_armed, zero padding above
  output logic [((NUM_KEYS+6+7)/8)*8-1:0] out_tdata,
  // Configuration writes.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);

  localparam int OUT_W   = ((NUM_KEYS + 6 + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - (NUM_KEYS + 6);

  kdb_cfg_t cfg_r;

  logic                s1_vld_r;
  logic [NUM_KEYS-1:0] s1_levels_r;
  logic [31:0]         s1_now_r;
  logic                advance;
  logic                s1_fire;

  kdb_key_ev_t         ev [NUM_KEYS];
  logic [NUM_KEYS-1:0] short_mask;
  logic                back;
  logic                run_nxt;
  logic                waiting_nxt;

  logic                out_vld_r;
  logic [NUM_KEYS-1:0] short_mask_r;
  logic                enter_r;
  logic                back_r;
  logic                run_r;
  logic                armed_r;
  logic                armed_seen_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= RST_DEBOUNCE_TICKS;
      cfg_r.long_press_ticks <= RST_LONG_PRESS_TICKS;
      cfg_r.toggle_delay_ms  <= RST_TOGGLE_DELAY_MS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS:   cfg_r.debounce_ticks   <= cfg_data[7:0];
        CFG_LONG_PRESS_TICKS: cfg_r.long_press_ticks <= cfg_data[7:0];
        CFG_TOGGLE_DELAY_MS:  cfg_r.toggle_delay_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register frees up when it is empty or being taken.
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || advance;
  assign s1_fire   = s1_vld_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_levels_r <= in_tdata[NUM_KEYS-1:0];
      s1_now_r    <= in_tdata[NUM_KEYS +: 32];
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kdb_key_fsm u_key (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (s1_fire),
      .pressed (~s1_levels_r[k]),
      .cfg     (cfg_r),
      .ev      (ev[k])
    );
    assign short_mask[k] = ev[k].tap;
  end

  assign back = ev[3].hold;

  kdb_run_toggle u_toggle (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (s1_fire),
    .arm             (short_mask[0]),
    .now_ms          (s1_now_r),
    .toggle_delay_ms (cfg_r.toggle_delay_ms),
    .run_nxt         (run_nxt),
    .waiting_nxt     (waiting_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      short_mask_r <= short_mask;
      enter_r      <= short_mask[3] & ~back;
      back_r       <= back;
      run_r        <= run_nxt;
      armed_r      <= waiting_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, armed_r, run_r, back_r, enter_r,
                       short_mask_r[2], short_mask_r[1], short_mask_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_seen_r <= 1'b0;
    end else if (s1_fire && short_mask[0]) begin
      armed_seen_r <= 1'b1;
    end
  end

  // Back takes priority over enter, so the two never show together.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(enter_r && back_r))
    else $error("enter and back requests set in the same word");

  // A word held in the input register is not lost while the output stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !advance) |=> (s1_vld_r && $stable(s1_now_r) && $stable(s1_levels_r)))
    else $error("input register word changed while stalled");

  // Key state only moves when a word passes to the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_vld_r)
    else $error("scan processed without producing a result word");

  // A pending toggle can only exist after a key 0 short press has been seen.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && waiting_nxt && !short_mask[0]) |-> armed_seen_r)
    else $error("toggle pending without having been armed");

endmodule
`default_nettype wire
